// ----- rtl/bhpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Shared codes and the sequencer state type for the heap unit.
// ----------------------------------------------------------------------------
package bhpq_pkg;

	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic ORDER_LARGEST_FIRST  = 1'b0;
	localparam logic ORDER_SMALLEST_FIRST = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_REM_RD,
		S_REM_TOP,
		S_SIFT_RD,
		S_SIFT_SEL,
		S_SIFT_CMP,
		S_SIFT_PUT,
		S_RESP
	} bhpq_state_t;

endpackage

// ----- rtl/bhpq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap unit channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface bhpq_in_if #(
	parameter int KEY_WIDTH = 32,
	parameter int TAG_WIDTH = 16
);
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [KEY_WIDTH-1:0] new_key;
	logic [TAG_WIDTH-1:0] new_tag;

	modport source (output valid, op, new_key, new_tag, input ready);
	modport sink   (input valid, op, new_key, new_tag, output ready);
endinterface

interface bhpq_out_if #(
	parameter int KEY_WIDTH = 32,
	parameter int TAG_WIDTH = 16,
	parameter int COUNT_W   = 7
);
	logic                 valid;
	logic                 ready;
	logic [KEY_WIDTH-1:0] out_key;
	logic [TAG_WIDTH-1:0] out_tag;
	logic [1:0]           status;
	logic [COUNT_W-1:0]   count_after;

	modport source (output valid, out_key, out_tag, status, count_after, input ready);
	modport sink   (input valid, out_key, out_tag, status, count_after, output ready);
endinterface

// ----- rtl/bhpq_yield.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap key comparator
// Shared ordering test: true when key a gives way to key b.
// ----------------------------------------------------------------------------
module bhpq_yield
	import bhpq_pkg::*;
#(
	parameter int KEY_WIDTH = 32
) (
	input  logic                 order,
	input  logic [KEY_WIDTH-1:0] key_a,
	input  logic [KEY_WIDTH-1:0] key_b,
	output logic                 yield
);

	// largest-first lets equal keys swap
	always_comb begin
		if (order == ORDER_LARGEST_FIRST) begin
			yield = (key_a <= key_b);
		end else begin
			yield = (key_a > key_b);
		end
	end

endmodule

// ----- rtl/binary_heap_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary heap priority queue unit
// Array-indexed binary heap with insert and remove-top, one shared comparator.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request words {op, new_key, new_tag}; op 0 inserts, op 1 removes
//            the top entry. Taken only while the sequencer is idle.
//   out_ch : one result word per request {out_key, out_tag, status,
//            count_after}. Key and tag are zero except for a good remove.
//   cfg_we / cfg_wdata : heap_order bit, 0 largest key first, 1 smallest.
//            Write only while the unit is idle.
// Sequencing: an insert reads and compares once per heap level on its path,
//   then writes the final slot and loads the result. A remove reads the
//   root and the old last slot, then reads, selects a child and compares
//   per level; the single comparator and the two-port read split each level
//   into these steps. Full or empty requests go straight to the result load.
// Throughput: one request at a time; a new request is taken the cycle after
// the previous result is loaded into the output register.
// Reset clears the count, the order bit and the output valid; the heap
// memory is not cleared; a slot past the count may be read but is never used.
// A stalled receiver holds the result register; the sequencer then waits in
// its response state and accepts nothing new.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_unit
	import bhpq_pkg::*;
#(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32,
	parameter int TAG_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	bhpq_in_if.sink    in_ch,
	bhpq_out_if.source out_ch
);

	localparam int CW = $clog2(CAPACITY + 1);   // count / slot number width
	localparam int AW = $clog2(CAPACITY);       // memory address width
	localparam int DW = $clog2(CW);             // path depth width
	localparam int EW = KEY_WIDTH + TAG_WIDTH;  // stored entry width

	// highest set bit of a slot number: depth of that slot below the root
	function automatic logic [DW-1:0] slot_depth(input logic [CW-1:0] slot);
		logic [DW-1:0] res;
		res = '0;
		for (int i = 0; i < CW; i++) begin
			if (slot[i]) begin
				res = DW'(i);
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	bhpq_state_t state_q, state_d;

	logic                 order_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        slot_q;     // insert target slot
	logic [DW-1:0]        lvl_q;      // insert path shift, counts down to 1
	logic [CW-1:0]        pos_q;      // sift-down hole position
	logic [CW-1:0]        cidx_q;     // chosen child slot
	logic [EW-1:0]        cur_q;      // entry carried along the path
	logic [EW-1:0]        child_q;    // chosen child entry
	logic [KEY_WIDTH-1:0] res_key_q;
	logic [TAG_WIDTH-1:0] res_tag_q;
	logic [STATUS_W-1:0]  res_status_q;

	logic                 out_valid_q;
	logic [KEY_WIDTH-1:0] out_key_q;
	logic [TAG_WIDTH-1:0] out_tag_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [CW-1:0]        out_count_q;

	// heap memory: slot n lives at address n-1
	logic [EW-1:0] mem [CAPACITY];
	logic [EW-1:0] rd_a_q, rd_b_q;

	// ------------------------------------------------------------------
	// Path arithmetic
	// ------------------------------------------------------------------
	logic [CW-1:0] node_idx, node_m1, slot_m1, pos_m1, next_slot;
	logic [CW:0]   left_idx, left_m1, cnt_ext;
	logic          left_out, right_in;

	assign node_idx  = slot_q >> lvl_q;
	assign node_m1   = node_idx - CW'(1);
	assign slot_m1   = slot_q - CW'(1);
	assign pos_m1    = pos_q - CW'(1);
	assign next_slot = cnt_q + CW'(1);
	assign left_idx  = {pos_q, 1'b0};
	assign left_m1   = left_idx - (CW+1)'(1);
	assign cnt_ext   = {1'b0, cnt_q};
	assign left_out  = (left_idx > cnt_ext);
	assign right_in  = (left_idx < cnt_ext);

	// ------------------------------------------------------------------
	// Shared comparator
	// ------------------------------------------------------------------
	logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
	logic                 cmp_yield;

	bhpq_yield #(
		.KEY_WIDTH(KEY_WIDTH)
	) u_yield (
		.order (order_q),
		.key_a (cmp_a),
		.key_b (cmp_b),
		.yield (cmp_yield)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic          in_fire, res_load;
	logic          rd_en;
	logic [AW-1:0] rd_addr_a, rd_addr_b;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign res_load = (state_q == S_RESP) && (!out_valid_q || out_ch.ready);

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr_a = '0;
		rd_addr_b = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = cur_q;
		cmp_a     = cur_q[EW-1 -: KEY_WIDTH];
		cmp_b     = cur_q[EW-1 -: KEY_WIDTH];
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (in_ch.op == OP_INSERT) begin
						if (cnt_q == CW'(CAPACITY)) begin
							state_d = S_RESP;
						end else if (cnt_q == '0) begin
							state_d = S_INS_PUT;
						end else begin
							state_d = S_INS_RD;
						end
					end else begin
						state_d = (cnt_q == '0) ? S_RESP : S_REM_RD;
					end
				end
			end
			S_INS_RD: begin
				rd_en     = 1'b1;
				rd_addr_a = node_m1[AW-1:0];
				state_d   = S_INS_CMP;
			end
			S_INS_CMP: begin
				// node gives way: drop carried entry here, carry the old one on
				cmp_a   = rd_a_q[EW-1 -: KEY_WIDTH];
				cmp_b   = cur_q[EW-1 -: KEY_WIDTH];
				wr_en   = cmp_yield;
				wr_addr = node_m1[AW-1:0];
				wr_data = cur_q;
				state_d = (lvl_q == DW'(1)) ? S_INS_PUT : S_INS_RD;
			end
			S_INS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = slot_m1[AW-1:0];
				wr_data = cur_q;
				state_d = S_RESP;
			end
			S_REM_RD: begin
				// root and old last slot; count already holds the new size
				rd_en     = 1'b1;
				rd_addr_a = '0;
				rd_addr_b = cnt_q[AW-1:0];
				state_d   = S_REM_TOP;
			end
			S_REM_TOP: begin
				state_d = S_SIFT_RD;
			end
			S_SIFT_RD: begin
				if (left_out) begin
					state_d = S_SIFT_PUT;
				end else begin
					rd_en     = 1'b1;
					rd_addr_a = left_m1[AW-1:0];
					rd_addr_b = left_idx[AW-1:0];
					state_d   = S_SIFT_SEL;
				end
			end
			S_SIFT_SEL: begin
				cmp_a   = rd_a_q[EW-1 -: KEY_WIDTH];
				cmp_b   = rd_b_q[EW-1 -: KEY_WIDTH];
				state_d = S_SIFT_CMP;
			end
			S_SIFT_CMP: begin
				// hole moves down: child rises into it
				cmp_a   = cur_q[EW-1 -: KEY_WIDTH];
				cmp_b   = child_q[EW-1 -: KEY_WIDTH];
				wr_en   = cmp_yield;
				wr_addr = pos_m1[AW-1:0];
				wr_data = child_q;
				state_d = cmp_yield ? S_SIFT_RD : S_SIFT_PUT;
			end
			S_SIFT_PUT: begin
				wr_en   = 1'b1;
				wr_addr = pos_m1[AW-1:0];
				wr_data = cur_q;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (res_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Memory
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_LARGEST_FIRST;
			cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
			if (in_fire) begin
				if (in_ch.op == OP_INSERT) begin
					if (cnt_q != CW'(CAPACITY)) begin
						cnt_q <= next_slot;
					end
				end else if (cnt_q != '0) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					res_key_q <= '0;
					res_tag_q <= '0;
					cur_q     <= {in_ch.new_key, in_ch.new_tag};
					slot_q    <= next_slot;
					lvl_q     <= slot_depth(next_slot);
					if (in_ch.op == OP_INSERT) begin
						res_status_q <= (cnt_q == CW'(CAPACITY)) ? STATUS_FULL : STATUS_OK;
					end else begin
						res_status_q <= (cnt_q == '0) ? STATUS_EMPTY : STATUS_OK;
					end
				end
			end
			S_INS_CMP: begin
				if (cmp_yield) begin
					cur_q <= rd_a_q;
				end
				lvl_q <= lvl_q - DW'(1);
			end
			S_REM_TOP: begin
				res_key_q <= rd_a_q[EW-1 -: KEY_WIDTH];
				res_tag_q <= rd_a_q[TAG_WIDTH-1:0];
				cur_q     <= rd_b_q;
				pos_q     <= CW'(1);
			end
			S_SIFT_SEL: begin
				// right child only when it exists and the left one gives way
				if (right_in && cmp_yield) begin
					child_q <= rd_b_q;
					cidx_q  <= CW'(left_idx + (CW+1)'(1));
				end else begin
					child_q <= rd_a_q;
					cidx_q  <= CW'(left_idx);
				end
			end
			S_SIFT_CMP: begin
				if (cmp_yield) begin
					pos_q <= cidx_q;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_key_q    <= res_key_q;
			out_tag_q    <= res_tag_q;
			out_status_q <= res_status_q;
			out_count_q  <= cnt_q;
		end
	end

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_key     = out_key_q;
	assign out_ch.out_tag     = out_tag_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.count_after = out_count_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == STATUS_FULL |-> out_count_q == CW'(CAPACITY))
		else $error("full status with heap not full");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == STATUS_EMPTY |-> out_count_q == '0 && out_key_q == '0)
		else $error("empty status with entries or key");

	a_ins_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_CMP |-> $past(state_q) == S_INS_RD)
		else $error("insert compare without read");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ch.ready)
		else $error("request taken while sequencer busy");

endmodule

// ----- sim/binary_heap_priority_queue_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap unit result checker
// Keeps a mirror of the heap, queues the result word each accepted request
// word should produce, and compares every result word the unit hands out.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_checker
	import bhpq_pkg::*;
#(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32,
	parameter int TAG_WIDTH = 16,
	parameter int COUNT_W   = 7
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	bhpq_in_if   in_ch,
	bhpq_out_if  out_ch,
	output int   mismatch_count,
	output int   results_owed,
	output int   results_seen,
	output int   full_drops,
	output int   empty_removes
);

	typedef struct packed {
		logic [KEY_WIDTH-1:0] key;
		logic [TAG_WIDTH-1:0] tag;
		logic [STATUS_W-1:0]  status;
		logic [COUNT_W-1:0]   count;
	} result_word_t;

	logic [KEY_WIDTH-1:0] mirror_key [1:CAPACITY];
	logic [TAG_WIDTH-1:0] mirror_tag [1:CAPACITY];
	int unsigned          mirror_live;
	logic                 mirror_order;
	result_word_t         owed_q [$];

	// true when key a has to give its place to key b
	function automatic bit gives_way(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
		if (mirror_order == ORDER_LARGEST_FIRST)
			return a <= b;
		return a > b;
	endfunction

	function automatic void swap_slots(int unsigned i, int unsigned j);
		logic [KEY_WIDTH-1:0] k;
		logic [TAG_WIDTH-1:0] t;
		k = mirror_key[i];
		t = mirror_tag[i];
		mirror_key[i] = mirror_key[j];
		mirror_tag[i] = mirror_tag[j];
		mirror_key[j] = k;
		mirror_tag[j] = t;
	endfunction

	// top-down insert: carry the new entry along the path to the new last slot
	function automatic void heap_push(logic [KEY_WIDTH-1:0] key, logic [TAG_WIDTH-1:0] tag);
		int unsigned          slot;
		int unsigned          depth;
		int unsigned          node;
		int                   d;
		logic [KEY_WIDTH-1:0] k;
		logic [TAG_WIDTH-1:0] t;
		slot  = mirror_live + 1;
		depth = 0;
		while ((slot >> (depth + 1)) != 0)
			depth++;
		for (d = depth; d >= 1; d--) begin
			node = slot >> d;
			if (gives_way(mirror_key[node], key)) begin
				k = mirror_key[node];
				t = mirror_tag[node];
				mirror_key[node] = key;
				mirror_tag[node] = tag;
				key = k;
				tag = t;
			end
		end
		mirror_key[slot] = key;
		mirror_tag[slot] = tag;
		mirror_live      = slot;
	endfunction

	function automatic void heap_sift(int unsigned n);
		int unsigned i;
		int unsigned l;
		int unsigned c;
		bit          done;
		i    = 1;
		done = 1'b0;
		while (!done) begin
			l = 2 * i;
			if (l > n) begin
				done = 1'b1;
			end else begin
				c = (l + 1 <= n && gives_way(mirror_key[l], mirror_key[l + 1])) ? l + 1 : l;
				if (!gives_way(mirror_key[i], mirror_key[c])) begin
					done = 1'b1;
				end else begin
					swap_slots(i, c);
					i = c;
				end
			end
		end
	endfunction

	function automatic result_word_t heap_apply(logic op, logic [KEY_WIDTH-1:0] key,
			logic [TAG_WIDTH-1:0] tag);
		result_word_t r;
		r.key    = '0;
		r.tag    = '0;
		r.status = STATUS_OK;
		if (op == OP_INSERT) begin
			if (mirror_live >= CAPACITY)
				r.status = STATUS_FULL;
			else
				heap_push(key, tag);
		end else if (mirror_live == 0) begin
			r.status = STATUS_EMPTY;
		end else begin
			r.key = mirror_key[1];
			r.tag = mirror_tag[1];
			mirror_key[1] = mirror_key[mirror_live];
			mirror_tag[1] = mirror_tag[mirror_live];
			mirror_live--;
			if (mirror_live > 1)
				heap_sift(mirror_live);
		end
		r.count = COUNT_W'(mirror_live);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 25)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		if (!arst_n) begin
			mirror_live    = 0;
			mirror_order   = ORDER_LARGEST_FIRST;
			owed_q.delete();
			mismatch_count = 0;
			results_owed   = 0;
			results_seen   = 0;
			full_drops     = 0;
			empty_removes  = 0;
		end else begin
			if (cfg_we)
				mirror_order = cfg_wdata;
			if (in_ch.valid && in_ch.ready)
				owed_q.push_back(heap_apply(in_ch.op, in_ch.new_key, in_ch.new_tag));
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (owed_q.size() == 0) begin
					report_mismatch($sformatf("result word with none owed (key 0x%0h status %0d)",
						out_ch.out_key, out_ch.status));
				end else begin
					want = owed_q.pop_front();
					if (want.status == STATUS_FULL)
						full_drops++;
					if (want.status == STATUS_EMPTY)
						empty_removes++;
					if (out_ch.out_key !== want.key)
						report_mismatch($sformatf("out_key expected 0x%0h, got 0x%0h",
							want.key, out_ch.out_key));
					if (out_ch.out_tag !== want.tag)
						report_mismatch($sformatf("out_tag expected 0x%0h, got 0x%0h",
							want.tag, out_ch.out_tag));
					if (out_ch.status !== want.status)
						report_mismatch($sformatf("status expected %0d, got %0d",
							want.status, out_ch.status));
					if (out_ch.count_after !== want.count)
						report_mismatch($sformatf("count_after expected %0d, got %0d",
							want.count, out_ch.count_after));
				end
			end
			results_owed = owed_q.size();
		end
	end

endmodule

// ----- sim/binary_heap_priority_queue_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap unit testbench
// Drives request words into the priority queue under both serving orders,
// with random gaps and back-pressure, and lets the checker score each result.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_unit_test;
	import bhpq_pkg::*;

	localparam int     CAPACITY      = 64;
	localparam int     KEY_WIDTH     = 32;
	localparam int     TAG_WIDTH     = 16;
	localparam int     CLK_HALF_NS   = 4;
	localparam int     RANDOM_PHASES = 6;
	localparam int     PHASE_WORDS   = 325;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     DRAIN_CYCLES  = 40;
	localparam longint TIMEOUT_NS    = 5_000_000;

	// where the random stream is steering the heap fill level
	typedef enum logic [1:0] {
		GROW,
		SHRINK,
		CHURN
	} fill_trend_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic cfg_wdata;

	bhpq_in_if  in_ch ();
	bhpq_out_if out_ch ();

	int          mismatch_count;
	int          results_owed;
	int          results_seen;
	int          full_drops;
	int          empty_removes;
	int          idle_pct;
	bit          hold_req;
	bit          hold_done;
	int          held;
	int          sent_inserts;
	int          sent_removes;
	int          order_writes;
	fill_trend_t trend;

	binary_heap_priority_queue_unit #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH),
		.TAG_WIDTH (TAG_WIDTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	binary_heap_priority_queue_checker #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH),
		.TAG_WIDTH (TAG_WIDTH)
	) u_result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed),
		.results_seen   (results_seen),
		.full_drops     (full_drops),
		.empty_removes  (empty_removes)
	);

	always begin
		#CLK_HALF_NS clk = 1'b1;
		#CLK_HALF_NS clk = 1'b0;
	end

	// Key mix: a crowd of tiny keys to force ties, the two extremes,
	// walking ones and zeros, and plain random values.
	function automatic logic [KEY_WIDTH-1:0] pick_key();
		logic [KEY_WIDTH-1:0] k;
		case ($urandom_range(0, 5))
			0:       k = KEY_WIDTH'($urandom_range(0, 7));
			1:       k = $urandom_range(0, 1) ? '1 : '0;
			2:       k = KEY_WIDTH'(1) << $urandom_range(0, KEY_WIDTH - 1);
			3:       k = ~(KEY_WIDTH'(1) << $urandom_range(0, KEY_WIDTH - 1));
			default: k = KEY_WIDTH'($urandom());
		endcase
		return k;
	endfunction

	function automatic logic [TAG_WIDTH-1:0] pick_tag();
		logic [TAG_WIDTH-1:0] t;
		if ($urandom_range(0, 7) == 0)
			t = $urandom_range(0, 1) ? '1 : '0;
		else
			t = TAG_WIDTH'($urandom());
		return t;
	endfunction

	// idle density for the next stretch; zero gives runs with no gaps at all
	function automatic int pick_idle();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 10;
			default: return 35;
		endcase
	endfunction

	// Offer one request word, optionally after a gap, and hold it until taken.
	// Track the fill level the way the heap would, to steer the stream.
	task automatic send_word(logic op, logic [KEY_WIDTH-1:0] key, logic [TAG_WIDTH-1:0] tag);
		@(negedge clk);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_ch.valid   = 1'b1;
		in_ch.op      = op;
		in_ch.new_key = key;
		in_ch.new_tag = tag;
		do @(posedge clk); while (!in_ch.ready);
		if (op == OP_INSERT) begin
			sent_inserts++;
			if (held < CAPACITY)
				held++;
		end else begin
			sent_removes++;
			if (held > 0)
				held--;
		end
	endtask

	// Drop valid, wait until every owed result word is back, then write the
	// order bit while the unit sits idle.
	task automatic write_order(logic order);
		@(negedge clk);
		in_ch.valid = 1'b0;
		wait (results_owed == 0);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = order;
		@(negedge clk);
		cfg_we = 1'b0;
		order_writes++;
	endtask

	// One random request. Grow until full (and a few drops past it), shrink
	// until empty (and a few empty removes), churn in between.
	task automatic random_word();
		int   ins_pct;
		logic op;
		case (trend)
			GROW:    ins_pct = 85;
			SHRINK:  ins_pct = 15;
			default: ins_pct = 50;
		endcase
		op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
		send_word(op, pick_key(), pick_tag());
		if (held == CAPACITY && trend == GROW && $urandom_range(0, 3) == 0)
			trend = $urandom_range(0, 1) ? SHRINK : CHURN;
		else if (held == 0 && trend == SHRINK && $urandom_range(0, 3) == 0)
			trend = $urandom_range(0, 1) ? GROW : CHURN;
		else if ($urandom_range(0, 59) == 0)
			trend = fill_trend_t'($urandom_range(0, 2));
	endtask

	// Receiver: random stalls, plus one long hold-off on request so the heap
	// unit backs up and stalls its request side.
	initial begin
		out_ch.ready = 1'b0;
		hold_done    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = ORDER_LARGEST_FIRST;
		in_ch.valid   = 1'b0;
		in_ch.op      = OP_INSERT;
		in_ch.new_key = '0;
		in_ch.new_tag = '0;
		idle_pct      = 0;
		hold_req      = 1'b0;
		held          = 0;
		sent_inserts  = 0;
		sent_removes  = 0;
		order_writes  = 0;
		trend         = GROW;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Largest first: empty remove, key and tag extremes, a three-way tie
		// on one key, then drain everything and go one past empty.
		write_order(ORDER_LARGEST_FIRST);
		send_word(OP_REMOVE, '1, '1);
		send_word(OP_INSERT, '0, '0);
		send_word(OP_INSERT, '1, '1);
		send_word(OP_INSERT, KEY_WIDTH'(5), 16'hAAAA);
		send_word(OP_INSERT, KEY_WIDTH'(5), 16'h5555);
		send_word(OP_INSERT, KEY_WIDTH'(5), 16'h1234);
		send_word(OP_INSERT, '1, '0);
		send_word(OP_INSERT, '0, '1);
		repeat (8) send_word(OP_REMOVE, '0, '0);

		// Smallest first: extremes and a tie, drained to one past empty.
		write_order(ORDER_SMALLEST_FIRST);
		send_word(OP_INSERT, '1, 16'h0F0F);
		send_word(OP_INSERT, '0, 16'hF0F0);
		send_word(OP_INSERT, KEY_WIDTH'(7), 16'h0001);
		send_word(OP_INSERT, KEY_WIDTH'(7), 16'h0002);
		repeat (5) send_word(OP_REMOVE, '1, '1);

		// Random phases alternate the order; the heap usually is not
		// empty at the flip, so entries placed under one order get served
		// under the other. The second phase starts with the long hold-off
		// while the stream keeps growing the heap. The last phase runs with
		// no gaps on either side.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_order(p[0] ? ORDER_LARGEST_FIRST : ORDER_SMALLEST_FIRST);
			if (p == 1) begin
				trend    = GROW;
				hold_req = 1'b1;
			end
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (i % 64 == 0)
					idle_pct = (p == RANDOM_PHASES - 1) ? 0 : pick_idle();
				random_word();
			end
		end

		// Wait out the last results, then give stray words time to show up.
		@(negedge clk);
		in_ch.valid = 1'b0;
		wait (results_owed == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d request words (%0d inserts, %0d removes) across %0d order writes.",
			sent_inserts + sent_removes, sent_inserts, sent_removes, order_writes);
		$display("Checked %0d result words, %0d full-heap drops, %0d removes from empty.",
			results_seen, full_drops, empty_removes);
		if (mismatch_count == 0 && results_owed == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Hard stop in case the unit hangs or loses a result word.
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d result words still owed", results_owed);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
